FILE: rtl/ts_hap_pkg.sv
// ----------------------------------------------------------------------------
// ts_hap_pkg
// Shared widths, field kind codes and the result type of the TS parser.
// ----------------------------------------------------------------------------
package ts_hap_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 42;
    localparam int ACC_W   = 48;

    // field kind tags
    localparam logic [KIND_W-1:0] KIND_HEADER      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_AF_LEN      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_AF_FLAGS    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PCR         = 4'd3;
    localparam logic [KIND_W-1:0] KIND_OPCR        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SPLICE      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PRIV_LEN    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_PRIV_BYTE   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_EXT_LEN     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_EXT_FLAGS   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_LTW         = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RATE        = 4'd11;
    localparam logic [KIND_W-1:0] KIND_SPLICE_TYPE = 4'd12;
    localparam logic [KIND_W-1:0] KIND_DTS         = 4'd13;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_result;

endpackage

FILE: rtl/ts_hap_parser.sv
// ----------------------------------------------------------------------------
// ts_hap_parser
// Byte-serial header / adaptation field parse state and field extraction.
// ----------------------------------------------------------------------------
module ts_hap_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [ts_hap_pkg::BYTE_W-1:0]  i_ts_byte,
    input  logic                           i_packet_start,
    output ts_hap_pkg::t_result            o_result
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_HDR       = 4'd1;
    localparam logic [3:0] PH_AF_LEN    = 4'd2;
    localparam logic [3:0] PH_AF_FLAGS  = 4'd3;
    localparam logic [3:0] PH_PCR       = 4'd4;
    localparam logic [3:0] PH_OPCR      = 4'd5;
    localparam logic [3:0] PH_SPLICE    = 4'd6;
    localparam logic [3:0] PH_PRIV_LEN  = 4'd7;
    localparam logic [3:0] PH_PRIV_DATA = 4'd8;
    localparam logic [3:0] PH_EXT_LEN   = 4'd9;
    localparam logic [3:0] PH_EXT_FLAGS = 4'd10;
    localparam logic [3:0] PH_LTW       = 4'd11;
    localparam logic [3:0] PH_RATE      = 4'd12;
    localparam logic [3:0] PH_SEAMLESS  = 4'd13;
    localparam logic [3:0] PH_SKIP      = 4'd14;

    localparam logic [2:0] HDR_BYTES  = 3'd4;
    localparam logic [2:0] CLK_BYTES  = 3'd6;
    localparam logic [2:0] LTW_BYTES  = 3'd2;
    localparam logic [2:0] RATE_BYTES = 3'd3;
    localparam logic [2:0] DTS_BYTES  = 3'd5;

    localparam int VW = ts_hap_pkg::VALUE_W;

    typedef struct packed {
        logic [3:0] phase;
        logic [4:0] af;
        logic [2:0] ext;
    } t_next;

    // next pending adaptation field section, its flag cleared
    function automatic t_next af_next(input logic [4:0] af, input logic [2:0] ext);
        t_next r;
        r.af    = af;
        r.ext   = ext;
        r.phase = PH_SKIP;
        priority if (af[4]) begin
            r.af[4] = 1'b0;
            r.phase = PH_PCR;
        end else if (af[3]) begin
            r.af[3] = 1'b0;
            r.phase = PH_OPCR;
        end else if (af[2]) begin
            r.af[2] = 1'b0;
            r.phase = PH_SPLICE;
        end else if (af[1]) begin
            r.af[1] = 1'b0;
            r.phase = PH_PRIV_LEN;
        end else if (af[0]) begin
            r.af[0] = 1'b0;
            r.phase = PH_EXT_LEN;
        end else begin
            r.phase = PH_SKIP;
        end
        return r;
    endfunction

    // next pending extension section, else back to the adaptation field
    function automatic t_next ext_next(input logic [4:0] af, input logic [2:0] ext);
        t_next r;
        r.af    = af;
        r.ext   = ext;
        r.phase = PH_SKIP;
        priority if (ext[2]) begin
            r.ext[2] = 1'b0;
            r.phase  = PH_LTW;
        end else if (ext[1]) begin
            r.ext[1] = 1'b0;
            r.phase  = PH_RATE;
        end else if (ext[0]) begin
            r.ext[0] = 1'b0;
            r.phase  = PH_SEAMLESS;
        end else begin
            r = af_next(af, ext);
        end
        return r;
    endfunction

    logic [3:0]                  r_phase, n_phase;
    logic [2:0]                  r_idx, n_idx;
    logic [7:0]                  r_arem, n_arem;
    logic [4:0]                  r_af, n_af;
    logic [2:0]                  r_ext, n_ext;
    logic [7:0]                  r_prem, n_prem;
    logic [ts_hap_pkg::ACC_W-1:0] r_acc, n_acc;

    logic [ts_hap_pkg::ACC_W-1:0] w_acc_sh;
    logic [2:0]                  w_idx_inc;
    logic [VW-1:0]               w_base;
    logic [VW-1:0]               w_pcr;
    logic [VW-1:0]               w_dts;
    logic [7:0]                  w_prem_dec;
    t_next                       w_nx;

    assign w_acc_sh  = {r_acc[ts_hap_pkg::ACC_W-9:0], i_ts_byte};
    assign w_idx_inc = r_idx + 3'd1;

    // clock reference: base * 300 + extension, 300 = 256 + 32 + 8 + 4
    assign w_base = {9'b0, w_acc_sh[47:15]};
    assign w_pcr  = (w_base << 8) + (w_base << 5) + (w_base << 3) + (w_base << 2)
                  + {33'b0, w_acc_sh[8:0]};

    // DTS_next_AU with marker bits dropped
    assign w_dts = {9'b0, w_acc_sh[35:33], w_acc_sh[31:24], w_acc_sh[23:17],
                    w_acc_sh[15:8], w_acc_sh[7:1]};

    assign w_prem_dec = (r_prem != 8'd0) ? r_prem - 8'd1 : r_prem;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_arem   = r_arem;
        n_af     = r_af;
        n_ext    = r_ext;
        n_prem   = r_prem;
        n_acc    = r_acc;
        w_nx     = '0;
        o_result = '0;

        if (i_packet_start) begin
            n_phase = PH_HDR;
            n_idx   = 3'd1;
            n_arem  = '0;
            n_af    = '0;
            n_ext   = '0;
            n_prem  = '0;
            n_acc   = {40'b0, i_ts_byte};
        end else begin
            unique case (r_phase)
                PH_IDLE, PH_SKIP: begin
                end
                PH_HDR: begin
                    n_acc = w_acc_sh;
                    if (w_idx_inc >= HDR_BYTES) begin
                        n_idx          = '0;
                        n_phase        = i_ts_byte[5] ? PH_AF_LEN : PH_SKIP;
                        o_result.valid = 1'b1;
                        o_result.kind  = ts_hap_pkg::KIND_HEADER;
                        o_result.value = {10'b0, w_acc_sh[31:0]};
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
                PH_AF_LEN: begin
                    n_arem         = i_ts_byte;
                    n_phase        = (i_ts_byte != 8'd0) ? PH_AF_FLAGS : PH_SKIP;
                    o_result.valid = 1'b1;
                    o_result.kind  = ts_hap_pkg::KIND_AF_LEN;
                    o_result.value = {34'b0, i_ts_byte};
                end
                default: begin
                    // inside the adaptation field, bounded by its length
                    if (r_arem == 8'd0 || r_phase > PH_SEAMLESS) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_arem = r_arem - 8'd1;
                        unique case (r_phase)
                            PH_AF_FLAGS: begin
                                w_nx           = af_next(i_ts_byte[4:0], r_ext);
                                n_phase        = w_nx.phase;
                                n_af           = w_nx.af;
                                n_ext          = w_nx.ext;
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_AF_FLAGS;
                                o_result.value = {34'b0, i_ts_byte};
                            end
                            PH_PCR, PH_OPCR: begin
                                n_acc = w_acc_sh;
                                if (w_idx_inc >= CLK_BYTES) begin
                                    n_idx          = '0;
                                    w_nx           = af_next(r_af, r_ext);
                                    n_phase        = w_nx.phase;
                                    n_af           = w_nx.af;
                                    n_ext          = w_nx.ext;
                                    o_result.valid = 1'b1;
                                    o_result.kind  = (r_phase == PH_PCR)
                                                   ? ts_hap_pkg::KIND_PCR
                                                   : ts_hap_pkg::KIND_OPCR;
                                    o_result.value = w_pcr;
                                end else begin
                                    n_idx = w_idx_inc;
                                end
                            end
                            PH_SPLICE: begin
                                w_nx           = af_next(r_af, r_ext);
                                n_phase        = w_nx.phase;
                                n_af           = w_nx.af;
                                n_ext          = w_nx.ext;
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_SPLICE;
                                o_result.value = {34'b0, i_ts_byte};
                            end
                            PH_PRIV_LEN: begin
                                n_prem = i_ts_byte;
                                if (i_ts_byte != 8'd0) begin
                                    n_phase = PH_PRIV_DATA;
                                end else begin
                                    w_nx    = af_next(r_af, r_ext);
                                    n_phase = w_nx.phase;
                                    n_af    = w_nx.af;
                                    n_ext   = w_nx.ext;
                                end
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_PRIV_LEN;
                                o_result.value = {34'b0, i_ts_byte};
                            end
                            PH_PRIV_DATA: begin
                                n_prem = w_prem_dec;
                                if (w_prem_dec == 8'd0) begin
                                    w_nx    = af_next(r_af, r_ext);
                                    n_phase = w_nx.phase;
                                    n_af    = w_nx.af;
                                    n_ext   = w_nx.ext;
                                end
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_PRIV_BYTE;
                                o_result.value = {34'b0, i_ts_byte};
                            end
                            PH_EXT_LEN: begin
                                n_phase        = PH_EXT_FLAGS;
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_EXT_LEN;
                                o_result.value = {34'b0, i_ts_byte};
                            end
                            PH_EXT_FLAGS: begin
                                w_nx           = ext_next(r_af, i_ts_byte[7:5]);
                                n_phase        = w_nx.phase;
                                n_af           = w_nx.af;
                                n_ext          = w_nx.ext;
                                o_result.valid = 1'b1;
                                o_result.kind  = ts_hap_pkg::KIND_EXT_FLAGS;
                                o_result.value = {39'b0, i_ts_byte[7:5]};
                            end
                            PH_LTW: begin
                                n_acc = w_acc_sh;
                                if (w_idx_inc >= LTW_BYTES) begin
                                    n_idx          = '0;
                                    w_nx           = ext_next(r_af, r_ext);
                                    n_phase        = w_nx.phase;
                                    n_af           = w_nx.af;
                                    n_ext          = w_nx.ext;
                                    o_result.valid = 1'b1;
                                    o_result.kind  = ts_hap_pkg::KIND_LTW;
                                    o_result.value = {26'b0, w_acc_sh[15:0]};
                                end else begin
                                    n_idx = w_idx_inc;
                                end
                            end
                            PH_RATE: begin
                                n_acc = w_acc_sh;
                                if (w_idx_inc >= RATE_BYTES) begin
                                    n_idx          = '0;
                                    w_nx           = ext_next(r_af, r_ext);
                                    n_phase        = w_nx.phase;
                                    n_af           = w_nx.af;
                                    n_ext          = w_nx.ext;
                                    o_result.valid = 1'b1;
                                    o_result.kind  = ts_hap_pkg::KIND_RATE;
                                    o_result.value = {20'b0, w_acc_sh[21:0]};
                                end else begin
                                    n_idx = w_idx_inc;
                                end
                            end
                            PH_SEAMLESS: begin
                                n_acc = w_acc_sh;
                                if (w_idx_inc >= DTS_BYTES) begin
                                    n_idx          = '0;
                                    w_nx           = ext_next(r_af, r_ext);
                                    n_phase        = w_nx.phase;
                                    n_af           = w_nx.af;
                                    n_ext          = w_nx.ext;
                                    o_result.valid = 1'b1;
                                    o_result.kind  = ts_hap_pkg::KIND_DTS;
                                    o_result.value = w_dts;
                                end else begin
                                    n_idx = w_idx_inc;
                                    // splice type rides in the first DTS byte
                                    if (w_idx_inc == 3'd1) begin
                                        o_result.valid = 1'b1;
                                        o_result.kind  = ts_hap_pkg::KIND_SPLICE_TYPE;
                                        o_result.value = {38'b0, i_ts_byte[7:4]};
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_SKIP;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_arem  <= '0;
            r_af    <= '0;
            r_ext   <= '0;
            r_prem  <= '0;
            r_acc   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_arem  <= n_arem;
            r_af    <= n_af;
            r_ext   <= n_ext;
            r_prem  <= n_prem;
            r_acc   <= n_acc;
        end
    end

endmodule

FILE: rtl/ts_hap_out_buf.sv
// ----------------------------------------------------------------------------
// ts_hap_out_buf
// Two-entry output register with skid slot for field results.
// ----------------------------------------------------------------------------
module ts_hap_out_buf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  ts_hap_pkg::t_result                 i_result,
    output logic                                o_space,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ts_hap_pkg::KIND_W-1:0]       o_field_kind,
    output logic [ts_hap_pkg::VALUE_W-1:0]      o_field_value
);

    logic                              r_main_valid;
    logic                              r_skid_valid;
    logic [ts_hap_pkg::KIND_W-1:0]     r_main_kind, r_skid_kind;
    logic [ts_hap_pkg::VALUE_W-1:0]    r_main_value, r_skid_value;
    logic                              w_pop;

    assign w_pop = r_main_valid && i_out_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_pop) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || w_pop) begin
            if (r_skid_valid) begin
                r_main_kind  <= r_skid_kind;
                r_main_value <= r_skid_value;
            end else begin
                r_main_kind  <= i_result.kind;
                r_main_value <= i_result.value;
            end
        end else if (i_push) begin
            r_skid_kind  <= i_result.kind;
            r_skid_value <= i_result.value;
        end
    end

    assign o_space       = !r_skid_valid;
    assign o_out_valid   = r_main_valid;
    assign o_field_kind  = r_main_kind;
    assign o_field_value = r_main_value;

endmodule

FILE: rtl/ts_header_adaptation_parser_top.sv
// A field result is registered in an output slot when its last byte is accepted.
// Throughput: one stream byte per cycle; bytes keep flowing while one result waits.
// Intake stalls only when both output slots are full (a second result held back).
// Reset: i_rst_n synchronous, active low; parse returns to idle, output slots empty.
// ----------------------------------------------------------------------------
// ts_header_adaptation_parser_top
// MPEG transport stream header and adaptation field parser, one byte a cycle.
// ----------------------------------------------------------------------------
//
// Structure:
//   ts_hap_parser  - parse phase, remaining counts, flag bytes and the 48-bit
//                    accumulator. Each accepted byte updates the state and
//                    may complete one field; the field value (including the
//                    PCR/OPCR base*300+ext shift-add) is formed combinationally
//                    from the state and the incoming byte.
//   ts_hap_out_buf - output register plus skid slot. The intake ready is the
//                    registered "skid slot empty" flag, so no combinational
//                    path runs from i_out_ready to o_in_ready.
//
// A packet_start byte abandons any partial parse and begins a new header;
// bytes before the first packet start, stuffing and payload produce nothing.
//
module ts_header_adaptation_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stream byte requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ts_hap_pkg::BYTE_W-1:0]      i_ts_byte,
    input  logic                               i_packet_start,
    // field result requests
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ts_hap_pkg::KIND_W-1:0]      o_field_kind,
    output logic [ts_hap_pkg::VALUE_W-1:0]     o_field_value
);

    logic                 w_space;
    logic                 w_accept;
    ts_hap_pkg::t_result  w_result;

    assign o_in_ready = w_space;
    assign w_accept   = i_in_valid && w_space;

    ts_hap_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_ts_byte      (i_ts_byte),
        .i_packet_start (i_packet_start),
        .o_result       (w_result)
    );

    // a result is queued only for an accepted byte that completes a field
    ts_hap_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_accept && w_result.valid),
        .i_result      (w_result),
        .o_space       (w_space),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_field_kind  (o_field_kind),
        .o_field_value (o_field_value)
    );

endmodule

FILE: rtl/ts_hap_checker.sv
// ----------------------------------------------------------------------------
// ts_hap_checker
// Port-level checks on the TS parser top, attached by bind.
// ----------------------------------------------------------------------------
module ts_hap_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_packet_start,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [ts_hap_pkg::KIND_W-1:0]      o_field_kind,
    input logic [ts_hap_pkg::VALUE_W-1:0]     o_field_value
);

    // nothing pending after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // intake only stalls behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("intake stalled with no result pending");

    // a sync byte never completes a field
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_packet_start && !o_out_valid |=> !o_out_valid)
        else $error("result produced by a packet start byte");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_field_kind) && $stable(o_field_value))
        else $error("stalled result changed");

endmodule

bind ts_header_adaptation_parser_top ts_hap_checker u_ts_hap_checker (.*);

FILE: tb/ts_field_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_field_checker
// Watches both channels of the TS parser, predicts each field, compares.
// ----------------------------------------------------------------------------
module ts_field_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [ts_hap_pkg::BYTE_W-1:0]     i_ts_byte,
    input  logic                              i_packet_start,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [ts_hap_pkg::KIND_W-1:0]     i_field_kind,
    input  logic [ts_hap_pkg::VALUE_W-1:0]    i_field_value,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked,
    output logic [15:0]                       o_kinds_seen
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_HDR, ST_AF_LEN, ST_AF_FLAGS, ST_PCR, ST_OPCR, ST_SPLICE,
        ST_PRIV_LEN, ST_PRIV_DATA, ST_EXT_LEN, ST_EXT_FLAGS, ST_LTW, ST_RATE,
        ST_SEAMLESS, ST_SKIP
    } t_phase;

    // predicted parser state
    t_phase                          st;
    logic [2:0]                      sub_idx;
    logic [1:0]                      afc;
    logic [7:0]                      af_left;
    logic [7:0]                      af_flags;
    logic [2:0]                      ext_flags;
    logic [7:0]                      priv_left;
    logic [ts_hap_pkg::ACC_W-1:0]    acc;

    ts_hap_pkg::t_result             fields_due[$];
    int                              err_count;
    int                              match_count;
    logic [15:0]                     kinds_seen;

    function automatic void clear_parse();
        st        = ST_IDLE;
        sub_idx   = '0;
        afc       = '0;
        af_left   = '0;
        af_flags  = '0;
        ext_flags = '0;
        priv_left = '0;
        acc       = '0;
    endfunction

    function automatic ts_hap_pkg::t_result hit(
            input logic [ts_hap_pkg::KIND_W-1:0]  k,
            input logic [ts_hap_pkg::VALUE_W-1:0] v);
        return '{1'b1, k, v};
    endfunction

    // shift one byte into the accumulator; true once n bytes are in
    function automatic bit shift_in(input logic [7:0] b, input int unsigned n);
        acc     = {acc[ts_hap_pkg::ACC_W-9:0], b};
        sub_idx = sub_idx + 3'd1;
        if (sub_idx >= n) begin
            sub_idx = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // sections are visited in stream order; each flag is consumed once
    function automatic t_phase next_af_section();
        if (af_flags[4]) begin af_flags[4] = 1'b0; return ST_PCR;      end
        if (af_flags[3]) begin af_flags[3] = 1'b0; return ST_OPCR;     end
        if (af_flags[2]) begin af_flags[2] = 1'b0; return ST_SPLICE;   end
        if (af_flags[1]) begin af_flags[1] = 1'b0; return ST_PRIV_LEN; end
        if (af_flags[0]) begin af_flags[0] = 1'b0; return ST_EXT_LEN;  end
        return ST_SKIP;
    endfunction

    function automatic t_phase next_ext_section();
        if (ext_flags[2]) begin ext_flags[2] = 1'b0; return ST_LTW;      end
        if (ext_flags[1]) begin ext_flags[1] = 1'b0; return ST_RATE;     end
        if (ext_flags[0]) begin ext_flags[0] = 1'b0; return ST_SEAMLESS; end
        return next_af_section();
    endfunction

    task automatic parse_ts_byte(input logic [7:0] b, input logic start,
                                 output ts_hap_pkg::t_result res);
        logic [63:0] wide;
        t_phase      cur;
        res = '0;
        if (start) begin
            clear_parse();
            acc     = {40'd0, b};
            sub_idx = 3'd1;
            st      = ST_HDR;
        end else begin
            case (st)
                ST_HDR: begin
                    if (shift_in(b, 4)) begin
                        afc = b[5:4];
                        st  = afc[1] ? ST_AF_LEN : ST_SKIP;
                        res = hit(ts_hap_pkg::KIND_HEADER, {10'd0, acc[31:0]});
                    end
                end
                ST_AF_LEN: begin
                    af_left = b;
                    st      = (b != 8'd0) ? ST_AF_FLAGS : ST_SKIP;
                    res     = hit(ts_hap_pkg::KIND_AF_LEN, {34'd0, b});
                end
                ST_IDLE, ST_SKIP: ;
                default: begin
                    if (af_left == 8'd0) begin
                        // adaptation field used up: rest is payload
                        st = ST_SKIP;
                    end else begin
                        af_left = af_left - 8'd1;
                        cur     = st;
                        case (cur)
                            ST_AF_FLAGS: begin
                                af_flags = b;
                                st       = next_af_section();
                                res      = hit(ts_hap_pkg::KIND_AF_FLAGS, {34'd0, b});
                            end
                            ST_PCR, ST_OPCR: begin
                                if (shift_in(b, 6)) begin
                                    wide = {31'd0, acc[47:15]} * 64'd300
                                         + {55'd0, acc[8:0]};
                                    res  = hit((cur == ST_PCR) ? ts_hap_pkg::KIND_PCR
                                                               : ts_hap_pkg::KIND_OPCR,
                                               wide[ts_hap_pkg::VALUE_W-1:0]);
                                    st   = next_af_section();
                                end
                            end
                            ST_SPLICE: begin
                                st  = next_af_section();
                                res = hit(ts_hap_pkg::KIND_SPLICE, {34'd0, b});
                            end
                            ST_PRIV_LEN: begin
                                priv_left = b;
                                st  = (b != 8'd0) ? ST_PRIV_DATA : next_af_section();
                                res = hit(ts_hap_pkg::KIND_PRIV_LEN, {34'd0, b});
                            end
                            ST_PRIV_DATA: begin
                                if (priv_left != 8'd0)
                                    priv_left = priv_left - 8'd1;
                                if (priv_left == 8'd0)
                                    st = next_af_section();
                                res = hit(ts_hap_pkg::KIND_PRIV_BYTE, {34'd0, b});
                            end
                            ST_EXT_LEN: begin
                                st  = ST_EXT_FLAGS;
                                res = hit(ts_hap_pkg::KIND_EXT_LEN, {34'd0, b});
                            end
                            ST_EXT_FLAGS: begin
                                ext_flags = b[7:5];
                                st        = next_ext_section();
                                res       = hit(ts_hap_pkg::KIND_EXT_FLAGS,
                                                {39'd0, b[7:5]});
                            end
                            ST_LTW: begin
                                if (shift_in(b, 2)) begin
                                    res = hit(ts_hap_pkg::KIND_LTW, {26'd0, acc[15:0]});
                                    st  = next_ext_section();
                                end
                            end
                            ST_RATE: begin
                                if (shift_in(b, 3)) begin
                                    res = hit(ts_hap_pkg::KIND_RATE, {20'd0, acc[21:0]});
                                    st  = next_ext_section();
                                end
                            end
                            ST_SEAMLESS: begin
                                if (shift_in(b, 5)) begin
                                    // DTS_next_AU with marker bits dropped
                                    res = hit(ts_hap_pkg::KIND_DTS,
                                              {9'd0, acc[35:33], acc[31:24],
                                               acc[23:17], acc[15:8], acc[7:1]});
                                    st  = next_ext_section();
                                end else if (sub_idx == 3'd1) begin
                                    res = hit(ts_hap_pkg::KIND_SPLICE_TYPE,
                                              {38'd0, b[7:4]});
                                end
                            end
                            default: st = ST_SKIP;
                        endcase
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        ts_hap_pkg::t_result want;
        ts_hap_pkg::t_result fresh;
        if (!i_rst_n) begin
            clear_parse();
            fields_due.delete();
            err_count   = 0;
            match_count = 0;
            kinds_seen  = '0;
        end else begin
            // results are registered before they leave, so compare first
            if (i_out_valid && i_out_ready) begin
                if (fields_due.size() == 0) begin
                    $error("unexpected field: kind %0d value 0x%0h",
                           i_field_kind, i_field_value);
                    err_count++;
                end else begin
                    want = fields_due.pop_front();
                    if (i_field_kind !== want.kind) begin
                        $error("field_kind: expected %0d, got %0d",
                               want.kind, i_field_kind);
                        err_count++;
                    end
                    if (i_field_value !== want.value) begin
                        $error("field_value: expected 0x%0h, got 0x%0h",
                               want.value, i_field_value);
                        err_count++;
                    end
                    match_count++;
                    kinds_seen[want.kind] = 1'b1;
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_ts_byte(i_ts_byte, i_packet_start, fresh);
                if (fresh.valid)
                    fields_due = {fields_due, fresh};
            end
        end
        o_errors     <= err_count;
        o_pending    <= fields_due.size();
        o_checked    <= match_count;
        o_kinds_seen <= kinds_seen;
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TS header and adaptation field parser.
// ----------------------------------------------------------------------------
// A short directed run hits the layout corners (no adaptation field, empty
// field, every section at its extremes, restarts and truncation); then mostly
// well-formed random packets with some noise and broken packets, under four
// request-pressure phases. ts_field_checker predicts and compares each field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT  = 5000;   // cycles with no request moving
    localparam int ITEM_TARGET  = 650;    // stream byte requests in the whole run
    localparam int DRAIN_CYCLES = 20;

    logic                            clk;
    logic                            rst_n        = 1'b0;
    logic                            in_valid     = 1'b0;
    logic                            in_ready;
    logic [ts_hap_pkg::BYTE_W-1:0]   ts_byte      = '0;
    logic                            packet_start = 1'b0;
    logic                            out_valid;
    logic                            out_ready    = 1'b0;
    logic [ts_hap_pkg::KIND_W-1:0]   field_kind;
    logic [ts_hap_pkg::VALUE_W-1:0]  field_value;

    int          errors;
    int          pending;
    int          checked;
    logic [15:0] kinds_seen;

    int          idle_pct  = 0;     // sender idle chance, percent
    int          stall_pct = 0;     // receiver stall chance, percent
    int          bytes_sent;
    int          packets_sent;
    int          quiet_cycles;
    logic [7:0]  pkt_bytes[$];

    ts_header_adaptation_parser_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_ts_byte      (ts_byte),
        .i_packet_start (packet_start),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_field_kind   (field_kind),
        .o_field_value  (field_value)
    );

    ts_field_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_ts_byte      (ts_byte),
        .i_packet_start (packet_start),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_field_kind   (field_kind),
        .i_field_value  (field_value),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_kinds_seen   (kinds_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: stalls at the rate of the current phase
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: a long stretch with no request moving on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // One byte request. Called at a rising edge; returns at the accepting edge.
    // Ready is looked at on the falling edge, where it is settled.
    task automatic send_byte(input logic [7:0] b, input logic s);
        bit ok;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        ts_byte      <= b;
        packet_start <= s;
        do begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end while (!ok);
        bytes_sent++;
    endtask

    // pkt_bytes goes out with the packet-start flag on its first byte
    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == 0);
        pkt_bytes.delete();
        packets_sent++;
    endtask

    // Sender holds off until every predicted field has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Random packet: header, then (mostly) an adaptation field built from its
    // flags with random content. Some get a bad length, some get cut off.
    task automatic random_packet();
        logic [7:0] rb;
        logic [7:0] flags;
        logic [7:0] xflags;
        logic [1:0] afc;
        logic [7:0] af[$];
        int         plen;
        int         af_len;
        int         i;
        int         keep;

        afc = ($urandom_range(9) < 2) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
        pkt_bytes = {pkt_bytes, (($urandom_range(7) == 0) ? rand_byte() : 8'h47)};
        pkt_bytes = {pkt_bytes, rand_byte()};
        pkt_bytes = {pkt_bytes, rand_byte()};
        rb = rand_byte();
        pkt_bytes = {pkt_bytes, {rb[7:6], afc, rb[3:0]}};

        if (afc[1]) begin
            flags = rand_byte();
            af = {af, flags};
            if (flags[4]) repeat (6) af = {af, rand_byte()};      // PCR
            if (flags[3]) repeat (6) af = {af, rand_byte()};      // OPCR
            if (flags[2]) af = {af, rand_byte()};                 // splice countdown
            if (flags[1]) begin
                // private data: usually short, now and then up to a full byte
                plen = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(4);
                af = {af, 8'(plen)};
                repeat (plen) af = {af, rand_byte()};
            end
            if (flags[0]) begin
                af = {af, rand_byte()};                           // ext length, unused
                xflags = rand_byte();
                af = {af, xflags};
                if (xflags[7]) repeat (2) af = {af, rand_byte()};
                if (xflags[6]) repeat (3) af = {af, rand_byte()};
                if (xflags[5]) repeat (5) af = {af, rand_byte()};
            end
            repeat ($urandom_range(2)) af = {af, 8'hFF};          // stuffing

            case ($urandom_range(9))
                0:       af_len = 0;
                1:       af_len = $urandom_range(af.size());      // field cut short
                2:       af_len = $urandom_range(255);
                default: af_len = af.size();
            endcase
            if (af_len > 255)
                af_len = 255;
            pkt_bytes = {pkt_bytes, 8'(af_len)};
            for (i = 0; i < af.size() && i < af_len; i++)
                pkt_bytes = {pkt_bytes, af[i]};
        end

        repeat ($urandom_range(3)) pkt_bytes = {pkt_bytes, rand_byte()};  // payload

        // broken packet: the next sync byte arrives early
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(pkt_bytes.size() - 1, 1);
            while (pkt_bytes.size() > keep)
                void'(pkt_bytes.pop_back());
        end
        send_packet();

        // line noise with stray packet-start flags
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(4, 1))
                send_byte(rand_byte(), $urandom_range(3) == 0);
        end
    endtask

    initial begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // bytes before any packet start are dropped
        send_byte(8'hA5, 1'b0);
        send_byte(8'h47, 1'b0);
        // control 1: payload only
        pkt_bytes = {8'h47, 8'h40, 8'h00, 8'h10, 8'hAA};
        send_packet();
        // control 0, sync byte wrong (passed through, not checked)
        pkt_bytes = {8'h00, 8'h00, 8'h00, 8'h0F};
        send_packet();
        // adaptation field of length zero: no flags byte
        pkt_bytes = {8'h47, 8'h1F, 8'hFF, 8'h20, 8'h00, 8'h55};
        send_packet();
        // every section present, all-ones PCR, zero OPCR, all-ones extension
        pkt_bytes = {8'h47, 8'hFF, 8'hFF, 8'h3F, 8'h1C, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
        send_packet();
        // private data with three bytes, then payload
        pkt_bytes = {8'h47, 8'h00, 8'h01, 8'h30, 8'h05, 8'h02,
                     8'h03, 8'h01, 8'h02, 8'h03, 8'h9C};
        send_packet();
        // splice countdown then a zero private length
        pkt_bytes = {8'h47, 8'h00, 8'h02, 8'h20, 8'h03, 8'h06, 8'h7F, 8'h00};
        send_packet();
        // new packet start in the middle of a PCR
        pkt_bytes = {8'h47, 8'h00, 8'h03, 8'h20, 8'h0C, 8'h10, 8'h12, 8'h34};
        send_packet();
        // OPCR cut short by the adaptation field length
        pkt_bytes = {8'h47, 8'h00, 8'h04, 8'h20, 8'h03, 8'h08,
                     8'hAB, 8'hCD, 8'hEE, 8'hEE};
        send_packet();
        // zero PCR, then seamless splice only: splice type and DTS_next_AU
        pkt_bytes = {8'h47, 8'h00, 8'h05, 8'h30, 8'h0E, 8'h11,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'h20, 8'h5A, 8'h12, 8'h34, 8'h56, 8'h78};
        send_packet();
        wait_drained();

        // ---- random, four pressure phases ----
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            while (bytes_sent < ITEM_TARGET * (phase + 1) / 4)
                random_packet();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d stream bytes in %0d packets over four stall mixes",
                 bytes_sent, packets_sent);
        $display("summary: %0d fields checked, %0d of 14 field kinds seen",
                 checked, $countones(kinds_seen));
        if (errors == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
